/* rtl/core/gts_pkg.sv */
// types shared by the geodesic triangle subdivision block
package gts_pkg;

	localparam int unsigned COORD_W = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] v1_x;
		logic signed [COORD_W-1:0] v1_y;
		logic signed [COORD_W-1:0] v1_z;
		logic signed [COORD_W-1:0] v2_x;
		logic signed [COORD_W-1:0] v2_y;
		logic signed [COORD_W-1:0] v2_z;
		logic signed [COORD_W-1:0] v3_x;
		logic signed [COORD_W-1:0] v3_y;
		logic signed [COORD_W-1:0] v3_z;
	} tri_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic signed [COORD_W-1:0] p1_z;
		logic signed [COORD_W-1:0] p2_x;
		logic signed [COORD_W-1:0] p2_y;
		logic signed [COORD_W-1:0] p2_z;
		logic signed [COORD_W-1:0] p3_x;
		logic signed [COORD_W-1:0] p3_y;
		logic signed [COORD_W-1:0] p3_z;
		logic                      last_of_four;
	} tri_out_t;

	typedef logic signed [COORD_W-1:0] coord_t;

endpackage

/* rtl/core/geodesic_triangle_subdivide.sv */
// geodesic triangle subdivision: midpoint normalize pipeline and result sequencer
//
//  channel   signals                 transfer
//  input     start, busy, vertices   edge with start high and busy low
//  output    strobe, result          every cycle with strobe high, no hold-off
//
// each triangle gives four results on consecutive cycles, and the output
// sequencer can load the next triangle while the last result is shown, so
// the sequencer sets the sustained throughput. the first result reaches the
// ports through the input register, two front stages, one setup stage, one
// restoring step per quotient bit (FRAC_BITS + 1 of them), one sequencer load.
// reset clears all valid bits and the sequencer; busy is high while the last
// pipeline stage holds a triangle the sequencer cannot take yet, and then the
// whole pipeline holds.
module geodesic_triangle_subdivide #(
	parameter int unsigned FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gts_pkg::tri_in_t  vertices,
	output logic              strobe,
	output gts_pkg::tri_out_t result
);
	import gts_pkg::*;

	localparam int unsigned W    = 2 * FRAC_BITS + 40;
	localparam int unsigned NW   = 34;
	localparam int unsigned MW   = 17;
	localparam int unsigned SQW  = 2 * MW;
	localparam int unsigned LAST = FRAC_BITS + 1;

	logic adv;

	// front stage 1: registered input
	logic    vld_s1;
	tri_in_t in_s1;

	// stage 2: edge sums as sign and magnitude
	logic          vld_s2;
	tri_in_t       vtx_s2;
	logic [MW-1:0] mag_s2 [9];
	logic          neg_s2 [9];

	// stage 3: squares
	logic           vld_s3;
	tri_in_t        vtx_s3;
	logic [SQW-1:0] sq_s3 [9];
	logic           neg_s3 [9];

	// restoring stages, index 0 is the setup stage
	logic                vld_s [LAST+1];
	tri_in_t             vtx_s [LAST+1];
	logic [NW-1:0]       n_s   [LAST+1][3];
	logic                neg_s [LAST+1][9];
	logic signed [W-1:0] r_s   [LAST+1][9];
	logic signed [W-1:0] p_s   [LAST+1][9];
	logic signed [W-1:0] q_s   [LAST+1][9];
	logic [FRAC_BITS:0]  m_s   [LAST+1][9];

	// sequencer
	logic       act_q;
	logic [1:0] cnt_q;
	coord_t     pt_q [6][3];
	logic       seq_free;

	assign seq_free = !act_q || (cnt_q == 2'd3);
	assign adv      = !vld_s[LAST] || seq_free;
	assign busy     = !adv;

	// edge sums
	logic signed [MW-1:0] sum_c [9];
	always_comb begin
		coord_t a [3];
		coord_t b [3];
		coord_t c [3];
		a[0] = in_s1.v1_x; a[1] = in_s1.v1_y; a[2] = in_s1.v1_z;
		b[0] = in_s1.v2_x; b[1] = in_s1.v2_y; b[2] = in_s1.v2_z;
		c[0] = in_s1.v3_x; c[1] = in_s1.v3_y; c[2] = in_s1.v3_z;
		for (int i = 0; i < 3; i++) begin
			sum_c[i]     = MW'(a[i]) + MW'(b[i]);
			sum_c[3 + i] = MW'(a[i]) + MW'(c[i]);
			sum_c[6 + i] = MW'(b[i]) + MW'(c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int j = 0; j <= LAST; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s[0] <= vld_s3;
			for (int j = 0; j < LAST; j++) vld_s[j+1] <= vld_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1  <= vertices;
			vtx_s2 <= in_s1;
			vtx_s3 <= vtx_s2;
			vtx_s[0] <= vtx_s3;
			for (int i = 0; i < 9; i++) begin
				neg_s2[i] <= sum_c[i][MW-1];
				mag_s2[i] <= sum_c[i][MW-1] ? MW'(-sum_c[i]) : MW'(sum_c[i]);
				sq_s3[i]  <= SQW'(mag_s2[i]) * SQW'(mag_s2[i]);
				neg_s3[i] <= neg_s2[i];
				neg_s[0][i] <= neg_s3[i];
				r_s[0][i] <= $signed(W'(sq_s3[i])) <<< (2 * FRAC_BITS + 2);
			end
			for (int e = 0; e < 3; e++) begin
				n_s[0][e] <= NW'(sq_s3[3*e]) + NW'(sq_s3[3*e+1]) + NW'(sq_s3[3*e+2]);
			end
		end
	end

	// setup of running values: t = 2m-1 = -1, p = t*t*n, q = t*n
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			p_s[0][i] = $signed(W'(n_s[0][i/3]));
			q_s[0][i] = -$signed(W'(n_s[0][i/3]));
			m_s[0][i] = '0;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar j = 0; j < LAST; j++) begin : g_step
		localparam int unsigned K = FRAC_BITS - j;
		for (genvar l = 0; l < 9; l++) begin : g_lane
			logic signed [W-1:0] nn;
			logic signed [W-1:0] cand;
			logic                ok;
			assign nn   = $signed(W'(n_s[j][l/3]));
			assign cand = p_s[j][l] + (q_s[j][l] <<< (K + 2)) + (nn <<< (2 * K + 2));
			assign ok   = cand <= r_s[j][l];
			always_ff @(posedge clk) begin
				if (adv) begin
					p_s[j+1][l]   <= ok ? cand : p_s[j][l];
					q_s[j+1][l]   <= ok ? q_s[j][l] + (nn <<< (K + 1)) : q_s[j][l];
					m_s[j+1][l]   <= m_s[j][l] | (ok ? (FRAC_BITS+1)'(1) << K : '0);
					r_s[j+1][l]   <= r_s[j][l];
					neg_s[j+1][l] <= neg_s[j][l];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				vtx_s[j+1] <= vtx_s[j];
				for (int e = 0; e < 3; e++) n_s[j+1][e] <= n_s[j][e];
			end
		end
	end

	// sign, zero-length case and saturation
	coord_t mid_c [9];
	always_comb begin
		for (int l = 0; l < 9; l++) begin
			if (n_s[LAST][l/3] == '0) begin
				mid_c[l] = '0;
			end else if (neg_s[LAST][l]) begin
				mid_c[l] = (m_s[LAST][l] >= 32768) ? -16'sd32768 :
					16'(16'd0 - 16'(m_s[LAST][l]));
			end else begin
				mid_c[l] = (m_s[LAST][l] > 32767) ? 16'sd32767 : 16'(m_s[LAST][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (seq_free) begin
			act_q <= vld_s[LAST];
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_free && vld_s[LAST]) begin
			pt_q[0][0] <= vtx_s[LAST].v1_x;
			pt_q[0][1] <= vtx_s[LAST].v1_y;
			pt_q[0][2] <= vtx_s[LAST].v1_z;
			pt_q[1][0] <= vtx_s[LAST].v2_x;
			pt_q[1][1] <= vtx_s[LAST].v2_y;
			pt_q[1][2] <= vtx_s[LAST].v2_z;
			pt_q[2][0] <= vtx_s[LAST].v3_x;
			pt_q[2][1] <= vtx_s[LAST].v3_y;
			pt_q[2][2] <= vtx_s[LAST].v3_z;
			for (int e = 0; e < 3; e++) begin
				for (int i = 0; i < 3; i++) pt_q[3+e][i] <= mid_c[3*e+i];
			end
		end
	end

	// points: v1, v2, v3, then midpoints a, b, c
	always_comb begin
		logic [2:0] s0, s1, s2;
		unique case (cnt_q)
			2'd0: begin s0 = 3'd0; s1 = 3'd3; s2 = 3'd4; end
			2'd1: begin s0 = 3'd3; s1 = 3'd1; s2 = 3'd5; end
			2'd2: begin s0 = 3'd3; s1 = 3'd4; s2 = 3'd5; end
			default: begin s0 = 3'd4; s1 = 3'd5; s2 = 3'd2; end
		endcase
		result.p1_x = pt_q[s0][0];
		result.p1_y = pt_q[s0][1];
		result.p1_z = pt_q[s0][2];
		result.p2_x = pt_q[s1][0];
		result.p2_y = pt_q[s1][1];
		result.p2_z = pt_q[s1][2];
		result.p3_x = pt_q[s2][0];
		result.p3_y = pt_q[s2][1];
		result.p3_z = pt_q[s2][2];
		result.last_of_four = (cnt_q == 2'd3);
	end

	assign strobe = act_q;

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the geodesic triangle subdivision block
module tb_top;
	import gts_pkg::*;

	localparam int unsigned FRAC = 14;
	localparam int unsigned LIMIT = 400000;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     start = 0;
	logic     busy;
	tri_in_t  vertices = '0;
	logic     strobe;
	tri_out_t result;

	tri_out_t pending_tris[$];
	int       mismatches = 0;
	int       cycles = 0;

	geodesic_triangle_subdivide #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vertices(vertices), .strobe(strobe), .result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[geodesic_triangle_subdivide] ERROR");
			$finish;
		end
	end

	// round(mag * 2^F / sqrt(n)), ties away from zero, by search on (2m-1)^2 * n <= 4 mag^2 2^2F
	function automatic longint unsigned unit_scale(longint unsigned mag, longint unsigned n);
		logic [127:0] rhs;
		logic [127:0] lhs;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned m;
		longint unsigned odd;
		rhs = 128'(mag * mag) << (2 * FRAC + 2);
		lo = 0;
		hi = 64'd1 << FRAC;
		while (lo < hi) begin
			m = lo + (hi - lo + 1) / 2;
			odd = 2 * m - 1;
			lhs = 128'(odd * odd) * 128'(n);
			if (lhs <= rhs) lo = m;
			else hi = m - 1;
		end
		return lo;
	endfunction

	function automatic coord_t sat_coord(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return coord_t'(v);
	endfunction

	function automatic vec_t sphere_midpoint(vec_t a, vec_t b);
		longint s[3];
		longint unsigned mg[3];
		longint unsigned n;
		longint v;
		coord_t c[3];
		vec_t r;
		s[0] = longint'(a.x) + longint'(b.x);
		s[1] = longint'(a.y) + longint'(b.y);
		s[2] = longint'(a.z) + longint'(b.z);
		n = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (s[i] < 0) ? -s[i] : s[i];
			n += mg[i] * mg[i];
		end
		for (int i = 0; i < 3; i++) begin
			v = 0;
			if (n != 0) begin
				v = longint'(unit_scale(mg[i], n));
				if (s[i] < 0) v = -v;
			end
			c[i] = sat_coord(v);
		end
		r.x = c[0]; r.y = c[1]; r.z = c[2];
		return r;
	endfunction

	function automatic tri_out_t make_tri(vec_t p, vec_t q, vec_t r, logic last);
		tri_out_t t;
		t.p1_x = p.x; t.p1_y = p.y; t.p1_z = p.z;
		t.p2_x = q.x; t.p2_y = q.y; t.p2_z = q.z;
		t.p3_x = r.x; t.p3_y = r.y; t.p3_z = r.z;
		t.last_of_four = last;
		return t;
	endfunction

	task automatic predict_subdivision(tri_in_t t);
		vec_t v1, v2, v3, ma, mb, mc;
		v1.x = t.v1_x; v1.y = t.v1_y; v1.z = t.v1_z;
		v2.x = t.v2_x; v2.y = t.v2_y; v2.z = t.v2_z;
		v3.x = t.v3_x; v3.y = t.v3_y; v3.z = t.v3_z;
		ma = sphere_midpoint(v1, v2);
		mb = sphere_midpoint(v1, v3);
		mc = sphere_midpoint(v2, v3);
		pending_tris.push_back(make_tri(v1, ma, mb, 1'b0));
		pending_tris.push_back(make_tri(ma, v2, mc, 1'b0));
		pending_tris.push_back(make_tri(ma, mb, mc, 1'b0));
		pending_tris.push_back(make_tri(mb, mc, v3, 1'b1));
	endtask

	// results hold for the whole strobe cycle, so sample mid-cycle
	always @(negedge clk) begin
		tri_out_t want;
		if (arst_n && strobe) begin
			if (pending_tris.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = pending_tris.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, result);
				end
			end
		end
	end

	// called just after a rising edge; leaves start high
	task automatic send_triangle(tri_in_t t);
		logic b;
		start <= 1'b1;
		vertices <= t;
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b) break;
		end
		predict_subdivision(t);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic tri_in_t pack_tri(vec_t a, vec_t b, vec_t c);
		tri_in_t t;
		t.v1_x = a.x; t.v1_y = a.y; t.v1_z = a.z;
		t.v2_x = b.x; t.v2_y = b.y; t.v2_z = b.z;
		t.v3_x = c.x; t.v3_y = c.y; t.v3_z = c.z;
		return t;
	endfunction

	function automatic vec_t vec3(int x, int y, int z);
		vec_t v;
		v.x = coord_t'(x); v.y = coord_t'(y); v.z = coord_t'(z);
		return v;
	endfunction

	function automatic vec_t random_unit();
		real x, y, z, l;
		do begin
			x = real'($urandom_range(0, 2000)) - 1000.0;
			y = real'($urandom_range(0, 2000)) - 1000.0;
			z = real'($urandom_range(0, 2000)) - 1000.0;
			l = $sqrt(x * x + y * y + z * z);
		end while (l < 1.0);
		return vec3($rtoi(x / l * 16384.0 + (x < 0 ? -0.5 : 0.5)),
			$rtoi(y / l * 16384.0 + (y < 0 ? -0.5 : 0.5)),
			$rtoi(z / l * 16384.0 + (z < 0 ? -0.5 : 0.5)));
	endfunction

	function automatic vec_t random_raw();
		return vec3($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535));
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_tris.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		tri_in_t d[$];
		// octahedron face, axis extremes
		d.push_back(pack_tri(vec3(16384, 0, 0), vec3(0, 16384, 0), vec3(0, 0, 16384)));
		d.push_back(pack_tri(vec3(-16384, 0, 0), vec3(0, -16384, 0), vec3(0, 0, -16384)));
		// opposite vertices: zero-length sums
		d.push_back(pack_tri(vec3(16384, 0, 0), vec3(-16384, 0, 0), vec3(0, 16384, 0)));
		d.push_back(pack_tri(vec3(0, 0, 16384), vec3(0, 0, -16384), vec3(0, 0, 16384)));
		d.push_back(pack_tri(vec3(0, 0, 0), vec3(0, 0, 0), vec3(0, 0, 0)));
		// equal vertices
		d.push_back(pack_tri(vec3(9459, 9459, 9459), vec3(9459, 9459, 9459),
			vec3(-9459, 9459, -9459)));
		// off the sphere
		d.push_back(pack_tri(vec3(1, 0, 0), vec3(0, 1, 0), vec3(1, 1, 1)));
		d.push_back(pack_tri(vec3(32767, 32767, 32767), vec3(32767, 32767, 32767),
			vec3(-32768, -32768, -32768)));
		d.push_back(pack_tri(vec3(-32768, -32768, -32768), vec3(-32768, 0, 0),
			vec3(32767, -1, 1)));
		d.push_back(pack_tri(vec3(-1, -1, -1), vec3(1, 1, 1), vec3(-1, 2, -3)));
		d.push_back(pack_tri(vec3(16384, 16384, 16384), vec3(-16384, -16384, 16384),
			vec3(16384, -16384, -16384)));
		d.push_back(pack_tri(vec3(3, 0, 0), vec3(0, 4, 0), vec3(0, 0, 12)));
		foreach (d[i]) begin
			send_triangle(d[i]);
			idle_gap();
		end
	endtask

	task automatic test_unit_sphere(int count);
		repeat (count) begin
			send_triangle(pack_tri(random_unit(), random_unit(), random_unit()));
			idle_gap();
		end
	endtask

	task automatic test_raw_patterns(int count);
		vec_t a;
		repeat (count) begin
			a = random_unit();
			case ($urandom_range(0, 2))
				0: send_triangle(pack_tri(random_raw(), random_raw(), random_raw()));
				1: send_triangle(pack_tri(a, vec3(-a.x, -a.y, -a.z), random_unit()));
				default: send_triangle(pack_tri(a, a, random_raw()));
			endcase
			idle_gap();
		end
	endtask

	task automatic test_drain_pause();
		send_triangle(pack_tri(random_unit(), random_unit(), random_unit()));
		wait_drained();
		test_unit_sphere(4);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_unit_sphere(120);
		test_drain_pause();
		test_raw_patterns(70);
		wait_drained();
		repeat (FRAC + 20) @(posedge clk);
		if (mismatches == 0 && pending_tris.size() == 0)
			$display("[geodesic_triangle_subdivide] OK");
		else
			$display("[geodesic_triangle_subdivide] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/gts_pkg.sv
rtl/core/geodesic_triangle_subdivide.sv
bench/tb_top.sv
